[design/assert_macros.svh]
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition must hold at every clock edge outside reset.
`define FSTS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// Consequence must hold in the same cycle as the antecedent.
`define FSTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Consequence must hold in the cycle after the antecedent.
`define FSTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FSTS_ASSERT_ALWAYS(lbl, cond)
`define FSTS_ASSERT_IMP(lbl, ante, cons)
`define FSTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/fsts_pkg.sv]
// Sequencer step codes, jump conditions and microcode table of the scheduler.
package fsts_pkg;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] S_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] S_DIV_INIT  = 4'd1;
  localparam logic [STEP_W-1:0] S_DIV_STEP  = 4'd2;
  localparam logic [STEP_W-1:0] S_LOAD_WR   = 4'd3;
  localparam logic [STEP_W-1:0] S_SCAN_INIT = 4'd4;
  localparam logic [STEP_W-1:0] S_SCAN_RD   = 4'd5;
  localparam logic [STEP_W-1:0] S_SCAN_END  = 4'd6;
  localparam logic [STEP_W-1:0] S_UPD_RD    = 4'd7;
  localparam logic [STEP_W-1:0] S_UPD_CALC  = 4'd8;
  localparam logic [STEP_W-1:0] S_UPD_WR    = 4'd9;
  localparam logic [STEP_W-1:0] S_IDLE_RES  = 4'd10;
  localparam logic [STEP_W-1:0] S_LAST      = S_IDLE_RES;

  localparam int JC_W = 3;

  localparam logic [JC_W-1:0] JC_NEXT      = 3'd0;
  localparam logic [JC_W-1:0] JC_JUMP      = 3'd1;
  localparam logic [JC_W-1:0] JC_DISPATCH  = 3'd2;
  localparam logic [JC_W-1:0] JC_LOOP_DIV  = 3'd3;
  localparam logic [JC_W-1:0] JC_LOOP_SCAN = 3'd4;
  localparam logic [JC_W-1:0] JC_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic [JC_W-1:0]   jc;
    logic [STEP_W-1:0] target;
    logic              div_init;
    logic              div_step;
    logic              wr_load;
    logic              scan_init;
    logic              scan_rd;
    logic              rd_best;
    logic              since_calc;
    logic              wr_upd;
    logic              idle_res;
    logic              need_out;
  } cw_t;

  // Control store: one control word per sequencer step.
  function automatic cw_t ucode(input logic [STEP_W-1:0] s);
    cw_t cw;
    cw = '0;
    unique case (s)
      S_IDLE: begin
        cw.jc     = JC_DISPATCH;
        cw.target = S_SCAN_INIT;
      end
      S_DIV_INIT: begin
        cw.jc       = JC_NEXT;
        cw.div_init = 1'b1;
      end
      S_DIV_STEP: begin
        cw.jc       = JC_LOOP_DIV;
        cw.target   = S_DIV_STEP;
        cw.div_step = 1'b1;
      end
      S_LOAD_WR: begin
        cw.jc      = JC_JUMP;
        cw.target  = S_IDLE;
        cw.wr_load = 1'b1;
      end
      S_SCAN_INIT: begin
        cw.jc        = JC_NEXT;
        cw.scan_init = 1'b1;
      end
      S_SCAN_RD: begin
        cw.jc      = JC_LOOP_SCAN;
        cw.target  = S_SCAN_RD;
        cw.scan_rd = 1'b1;
      end
      S_SCAN_END: begin
        cw.jc = JC_NEXT;
      end
      S_UPD_RD: begin
        cw.jc      = JC_NOT_FOUND;
        cw.target  = S_IDLE_RES;
        cw.rd_best = 1'b1;
      end
      S_UPD_CALC: begin
        cw.jc         = JC_NEXT;
        cw.since_calc = 1'b1;
      end
      S_UPD_WR: begin
        cw.jc       = JC_JUMP;
        cw.target   = S_IDLE;
        cw.wr_upd   = 1'b1;
        cw.need_out = 1'b1;
      end
      S_IDLE_RES: begin
        cw.jc       = JC_JUMP;
        cw.target   = S_IDLE;
        cw.idle_res = 1'b1;
        cw.need_out = 1'b1;
      end
      default: begin
        cw.jc     = JC_JUMP;
        cw.target = S_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

[design/fsts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fsts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/fair_share_tick_scheduler_top.sv]
// Fair-share tick scheduler: microcoded sequencer over a per-slot task record RAM.
// A load word has its vruntime increment 2^FRAC_BITS/prio formed by a restoring
// divider, one quotient bit a cycle. A tick word scans the slots, reading one slot
// record a cycle from the single read port. Its result word is valid the cycle after
// the last step.
// Synchronous reset clears the sequencer, the per-slot valid bits, the clock and the output.
`include "assert_macros.svh"

module fair_share_tick_scheduler_top #(
  parameter int SLOTS     = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [3:0]  slot,
  input  logic [15:0] arrival,
  input  logic [15:0] burst,
  input  logic [7:0]  prio,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  ran_slot,
  output logic        idle,
  output logic        finished,
  output logic [15:0] wait_total,
  output logic [15:0] turnaround,
  output logic [15:0] now
);

  localparam int IW = $clog2(SLOTS);
  localparam int QW = FRAC_BITS + 1;
  localparam int CW = $clog2(FRAC_BITS + 2);

  // One task slot as it sits in the record RAM.
  typedef struct packed {
    logic [15:0]   arrival;
    logic [15:0]   burst;
    logic [15:0]   remaining;
    logic [QW-1:0] incr;
    logic [31:0]   vrun;
    logic [15:0]   waiting;
    logic [15:0]   last_run;
  } rec_t;

  // Sequencer state. The control word of the current step drives the datapath below.
  logic [fsts_pkg::STEP_W-1:0] step;
  logic [fsts_pkg::STEP_W-1:0] step_next;
  fsts_pkg::cw_t               cw;
  logic                        go;
  logic                        accept_in;

  // Latched load word and the divider that forms the vruntime increment.
  logic [3:0]    ld_slot;
  logic [15:0]   ld_arr;
  logic [15:0]   ld_burst;
  logic [7:0]    div_w;
  logic [7:0]    div_r;
  logic [QW-1:0] div_q;
  logic [CW-1:0] div_cnt;
  logic [8:0]    div_sh;
  logic [8:0]    div_sub;
  logic          div_ge;
  logic [IW-1:0] ld_idx;
  logic          ld_ok;

  // Scan state: the minimum search runs one slot behind the RAM read address.
  logic [IW-1:0] scan_idx;
  logic          pend;
  logic [IW-1:0] pend_idx;
  logic          found;
  logic [IW-1:0] best;
  logic [31:0]   best_vr;
  logic          cand;
  logic          better;

  // Per-slot valid bits stand in for the reset value of the record RAM.
  logic [SLOTS-1:0] valid;
  logic [15:0]      clock_now;
  logic [15:0]      clock_next;

  // Update of the chosen slot.
  logic [15:0] ref_time;
  logic [15:0] since_q;
  logic [16:0] wait_sum;
  logic [15:0] wait_new;
  logic [32:0] vr_sum;
  logic [31:0] vr_new;
  logic [15:0] rem_new;
  logic [15:0] turn_new;

  // Record RAM ports.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  rec_t          ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  rec_t          ram_rdata;

  assign cw        = fsts_pkg::ucode(step);
  assign in_ready  = (step == fsts_pkg::S_IDLE);
  assign accept_in = in_valid && in_ready;

  // A step that produces a result waits while the output register still holds an
  // untaken word; every action of that step is held off along with the step counter.
  assign go = !(cw.need_out && out_valid && !out_ready);

  always_comb begin
    step_next = step + fsts_pkg::STEP_W'(1);
    unique case (cw.jc)
      fsts_pkg::JC_NEXT: begin
        step_next = step + fsts_pkg::STEP_W'(1);
      end
      fsts_pkg::JC_JUMP: begin
        step_next = cw.target;
      end
      fsts_pkg::JC_DISPATCH: begin
        if (!accept_in) begin
          step_next = step;
        end else if (func) begin
          step_next = cw.target;
        end else begin
          step_next = step + fsts_pkg::STEP_W'(1);
        end
      end
      fsts_pkg::JC_LOOP_DIV: begin
        if (div_cnt != CW'(1)) begin
          step_next = cw.target;
        end
      end
      fsts_pkg::JC_LOOP_SCAN: begin
        if (scan_idx != IW'(SLOTS - 1)) begin
          step_next = cw.target;
        end
      end
      fsts_pkg::JC_NOT_FOUND: begin
        if (!found) begin
          step_next = cw.target;
        end
      end
      default: begin
        step_next = fsts_pkg::S_IDLE;
      end
    endcase
    if (!go) begin
      step_next = step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= fsts_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Input capture. A priority of zero weighs as one.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      ld_slot  <= slot;
      ld_arr   <= arrival;
      ld_burst <= burst;
      div_w    <= (prio == 8'd0) ? 8'd1 : prio;
    end
  end

  // Restoring division of 2^FRAC_BITS by the weight: the dividend starts in the quotient
  // register and shifts out at the top while quotient bits shift in at the bottom.
  assign div_sh  = {div_r, div_q[QW-1]};
  assign div_ge  = (div_sh >= {1'b0, div_w});
  assign div_sub = div_sh - {1'b0, div_w};

  always_ff @(posedge clk) begin
    if (cw.div_init) begin
      div_r   <= 8'd0;
      div_q   <= {1'b1, {FRAC_BITS{1'b0}}};
      div_cnt <= CW'(QW);
    end else if (cw.div_step) begin
      div_r   <= div_ge ? div_sub[7:0] : div_sh[7:0];
      div_q   <= {div_q[QW-2:0], div_ge};
      div_cnt <= div_cnt - CW'(1);
    end
  end

  assign ld_idx = IW'(ld_slot);
  assign ld_ok  = (32'(ld_slot) < 32'(SLOTS));

  // A slot competes when it was loaded, still has time left and has arrived. Ties keep
  // the earlier, lower slot because only a strictly smaller vruntime replaces the best.
  assign cand   = pend && valid[pend_idx] && (ram_rdata.remaining != 16'd0) &&
                  (ram_rdata.arrival <= clock_now);
  assign better = cand && (!found || (ram_rdata.vrun < best_vr));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      pend  <= 1'b0;
    end else if (go) begin
      pend <= cw.scan_rd;
      if (cw.scan_init) begin
        found <= 1'b0;
      end else if (better) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= scan_idx;
    if (cw.scan_init) begin
      scan_idx <= '0;
    end else if (cw.scan_rd) begin
      scan_idx <= scan_idx + IW'(1);
    end
    if (better) begin
      best    <= pend_idx;
      best_vr <= ram_rdata.vrun;
    end
  end

  // Waiting time since the slot last ran, or since arrival on its first run.
  assign ref_time = (ram_rdata.burst == ram_rdata.remaining) ? ram_rdata.arrival
                                                             : ram_rdata.last_run;

  always_ff @(posedge clk) begin
    if (cw.since_calc) begin
      since_q <= (clock_now >= ref_time) ? (clock_now - ref_time) : 16'd0;
    end
  end

  assign clock_next = (clock_now == 16'hFFFF) ? clock_now : (clock_now + 16'd1);
  assign wait_sum   = {1'b0, ram_rdata.waiting} + {1'b0, since_q};
  assign wait_new   = wait_sum[16] ? 16'hFFFF : wait_sum[15:0];
  assign vr_sum     = {1'b0, ram_rdata.vrun} + 33'(ram_rdata.incr);
  assign vr_new     = vr_sum[32] ? 32'hFFFF_FFFF : vr_sum[31:0];
  assign rem_new    = ram_rdata.remaining - 16'd1;
  assign turn_new   = (clock_next >= ram_rdata.arrival) ? (clock_next - ram_rdata.arrival)
                                                        : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_now <= 16'd0;
    end else if (go && (cw.wr_upd || cw.idle_res)) begin
      clock_now <= clock_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cw.wr_load && ld_ok) begin
      valid[ld_idx] <= 1'b1;
    end
  end

  // Record RAM access. Reads and writes never fall in the same step.
  assign ram_re    = cw.scan_rd || (cw.rd_best && found);
  assign ram_raddr = cw.scan_rd ? scan_idx : best;
  assign ram_we    = (cw.wr_load && ld_ok) || (cw.wr_upd && go);
  assign ram_waddr = cw.wr_load ? ld_idx : best;

  always_comb begin
    ram_wdata = ram_rdata;
    if (cw.wr_load) begin
      ram_wdata.arrival   = ld_arr;
      ram_wdata.burst     = ld_burst;
      ram_wdata.remaining = ld_burst;
      ram_wdata.incr      = div_q;
      ram_wdata.vrun      = 32'd0;
      ram_wdata.waiting   = 16'd0;
      ram_wdata.last_run  = ld_arr;
    end else begin
      ram_wdata.remaining = rem_new;
      ram_wdata.vrun      = vr_new;
      ram_wdata.waiting   = wait_new;
      ram_wdata.last_run  = clock_next;
    end
  end

  fsts_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (SLOTS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register. A new word is loaded only when the previous one has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && (cw.wr_upd || cw.idle_res)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && cw.wr_upd) begin
      ran_slot   <= 4'(best);
      idle       <= 1'b0;
      finished   <= (rem_new == 16'd0);
      wait_total <= wait_new;
      turnaround <= (rem_new == 16'd0) ? turn_new : 16'd0;
      now        <= clock_next;
    end else if (go && cw.idle_res) begin
      ran_slot   <= 4'd0;
      idle       <= 1'b1;
      finished   <= 1'b0;
      wait_total <= 16'd0;
      turnaround <= 16'd0;
      now        <= clock_next;
    end
  end

  `FSTS_ASSERT_ALWAYS(a_step_in_program, step <= fsts_pkg::S_LAST)
  `FSTS_ASSERT_NEXT(a_tick_starts_scan, accept_in && func, step == fsts_pkg::S_SCAN_INIT)
  `FSTS_ASSERT_IMP(a_update_hits_loaded_slot, ram_we && cw.wr_upd, valid[best])
  `FSTS_ASSERT_IMP(a_div_remainder_bound, cw.div_step, div_r < div_w)

endmodule
